/* src/assert_macros.svh */
// Assertion macros for the checker file of the project.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the reset term is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while the reset term is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* src/pse_pkg.sv */
// Types, constants and helper functions of the PNG stored-stream encoder.
// Depends on nothing; every module of the encoder imports it.
package pse_pkg;

   localparam logic OP_START = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
   localparam logic [16:0] ADLER_MOD = 17'd65521;

   typedef struct packed {
      logic       op;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       file_end;
      logic       error;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_PIXEL,
      CMD_ERROR
   } cmd_kind_type;

   // One classified item handed from the front part to the back part.
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
      logic         first_col;
      logic         last_pix;
      logic [15:0]  width;
      logic [15:0]  height;
      logic [34:0]  raw_len;
      logic [31:0]  zlen;
   } cmd_type;

   typedef enum logic [2:0] {
      FR_ACCEPT,
      FR_MUL,
      FR_SETUP,
      FR_RECIP,
      FR_EST,
      FR_PROD,
      FR_FIX,
      FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_START,
      BK_RAW,
      BK_TRAIL,
      BK_ERR
   } back_state_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] adler_mod(input logic [16:0] s);
      logic [16:0] r;
      r = (s >= ADLER_MOD) ? (s - ADLER_MOD) : s;
      return r[15:0];
   endfunction

endpackage

/* src/pse_front.sv */
// Front part: accepts start and pixel requests, tracks the image position and
// works out the IDAT length for a start. Depends on pse_pkg.
module pse_front #(
   parameter int BLOCK_MAX = 65535
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pse_pkg::req_type req_payload,
   input  logic [15:0]      image_width,
   input  logic [15:0]      image_height,
   input  logic             q_full,
   output logic             q_push,
   output pse_pkg::cmd_type q_data
);
   import pse_pkg::*;

   localparam logic [15:0] BLK_SIZE = (BLOCK_MAX < 2) ? 16'd2 : 16'(BLOCK_MAX);
   // Block size reciprocal scaled by 2^32; the quotient it gives is low by at most five.
   localparam logic [63:0] RECIP_WIDE = 64'h1_0000_0000 / {48'd0, BLK_SIZE};
   localparam logic [31:0] RECIP = RECIP_WIDE[31:0];

   front_state_type fst_ff, fst_in;
   logic        open_ff, open_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] lat_w_ff, lat_w_in;
   logic [15:0] lat_h_ff, lat_h_in;
   logic [34:0] raw_ff, raw_in;
   logic [34:0] dvd_ff, dvd_in;
   logic [50:0] phi_ff, phi_in;
   logic [47:0] plo_ff, plo_in;
   logic [34:0] quo_ff, quo_in;
   logic [34:0] rem_ff, rem_in;

   logic        accept;
   logic [16:0] col_next;
   logic [16:0] row_next;
   logic        row_end;
   logic        img_end;
   logic [66:0] est;
   logic [34:0] prod;
   logic [31:0] zlen;

   always_ff @(posedge clock) begin
      if (reset) begin
         fst_ff  <= FR_ACCEPT;
         open_ff <= 1'b0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         fst_ff  <= fst_in;
         open_ff <= open_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
      lat_w_ff <= lat_w_in;
      lat_h_ff <= lat_h_in;
      raw_ff   <= raw_in;
      dvd_ff   <= dvd_in;
      phi_ff   <= phi_in;
      plo_ff   <= plo_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
   end

   always_comb begin
      fst_in   = fst_ff;
      open_in  = open_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      lat_w_in = lat_w_ff;
      lat_h_in = lat_h_ff;
      raw_in   = raw_ff;
      dvd_in   = dvd_ff;
      phi_in   = phi_ff;
      plo_in   = plo_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      q_push   = 1'b0;

      req_ready = (fst_ff == FR_ACCEPT) && !q_full;
      accept    = req_valid && req_ready;

      col_next = {1'b0, col_ff} + 17'd1;
      row_next = {1'b0, row_ff} + 17'd1;
      row_end  = col_next >= {1'b0, lat_w_ff};
      img_end  = row_end && (row_next >= {1'b0, lat_h_ff});

      est  = {phi_ff, 16'd0} + {19'd0, plo_ff};
      prod = 35'(quo_ff * BLK_SIZE);
      zlen = raw_ff[31:0] + {quo_ff[29:0], 2'b00} + quo_ff[31:0] + 32'd6;

      q_data           = '0;
      q_data.kind      = CMD_PIXEL;
      q_data.red       = req_payload.red;
      q_data.green     = req_payload.green;
      q_data.blue      = req_payload.blue;
      q_data.first_col = (col_ff == 16'd0);
      q_data.last_pix  = img_end;
      q_data.width     = lat_w_ff;
      q_data.height    = lat_h_ff;
      q_data.raw_len   = raw_ff;
      q_data.zlen      = zlen;

      unique case (fst_ff)
         FR_ACCEPT: begin
            if (accept) begin
               if (req_payload.op == OP_START) begin
                  lat_w_in = (image_width == 16'd0) ? 16'd1 : image_width;
                  lat_h_in = (image_height == 16'd0) ? 16'd1 : image_height;
                  open_in  = 1'b1;
                  col_in   = '0;
                  row_in   = '0;
                  fst_in   = FR_MUL;
               end else if (!open_ff) begin
                  q_push      = 1'b1;
                  q_data.kind = CMD_ERROR;
               end else begin
                  q_push = 1'b1;
                  if (row_end) begin
                     col_in = '0;
                     row_in = row_next[15:0];
                     if (img_end) begin
                        open_in = 1'b0;
                     end
                  end else begin
                     col_in = col_next[15:0];
                  end
               end
            end
         end
         FR_MUL: begin
            // Raw scanline bytes: one filter byte and three samples per pixel per row.
            raw_in = 35'(lat_h_ff * ({2'b00, lat_w_ff} * 18'd3 + 18'd1));
            fst_in = FR_SETUP;
         end
         FR_SETUP: begin
            dvd_in = raw_ff + {19'd0, BLK_SIZE} - 35'd1;
            fst_in = FR_RECIP;
         end
         FR_RECIP: begin
            // Upper and lower halves of the dividend times the scaled reciprocal.
            phi_in = 51'(dvd_ff[34:16] * RECIP);
            plo_in = 48'(dvd_ff[15:0] * RECIP);
            fst_in = FR_EST;
         end
         FR_EST: begin
            quo_in = est[66:32];
            fst_in = FR_PROD;
         end
         FR_PROD: begin
            rem_in = dvd_ff - prod;
            fst_in = FR_FIX;
         end
         FR_FIX: begin
            // The estimate is never high, so the remainder only has to come down.
            if (rem_ff >= {19'd0, BLK_SIZE}) begin
               rem_in = rem_ff - {19'd0, BLK_SIZE};
               quo_in = quo_ff + 35'd1;
            end else begin
               fst_in = FR_PUSH;
            end
         end
         FR_PUSH: begin
            if (!q_full) begin
               q_push      = 1'b1;
               q_data.kind = CMD_START;
               fst_in      = FR_ACCEPT;
            end
         end
         default: fst_in = FR_ACCEPT;
      endcase
   end

endmodule

/* src/pse_queue.sv */
// Short command queue between the front and back parts of the encoder.
// Depends on pse_pkg.
module pse_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pse_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output pse_pkg::cmd_type head_data
);
   import pse_pkg::*;

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_comb begin
      full       = (cnt_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
      head_valid = (cnt_ff != '0);
      head_data  = mem_ff[rd_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_in      = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in      = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in     = cnt_ff + {{QPTR_W{1'b0}}, do_push} - {{QPTR_W{1'b0}}, do_pop};
   end

endmodule

/* src/pse_back.sv */
// Back part: turns queued commands into PNG bytes, one byte per cycle while the
// response side takes them, and keeps the CRC-32, Adler-32 and stored-block counts. Depends on pse_pkg.
module pse_back #(
   parameter int BLOCK_MAX = 65535
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  pse_pkg::cmd_type q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pse_pkg::rsp_type rsp_payload
);
   import pse_pkg::*;

   localparam logic [15:0] BLK_SIZE = (BLOCK_MAX < 2) ? 16'd2 : 16'(BLOCK_MAX);
   localparam logic [5:0]  START_LAST = 6'd42;
   localparam logic [5:0]  TRAIL_LAST = 6'd19;

   back_state_type state_ff, state_in;
   logic        cur_valid_ff, cur_valid_in;
   cmd_type     cur_ff, cur_in;
   logic [5:0]  idx_ff, idx_in;
   logic [1:0]  rsel_ff, rsel_in;
   logic [2:0]  hdr_idx_ff, hdr_idx_in;
   logic        hdr_done_ff, hdr_done_in;
   logic [31:0] crc_ff, crc_in;
   logic [15:0] adl_lo_ff, adl_lo_in;
   logic [15:0] adl_hi_ff, adl_hi_in;
   logic [15:0] blk_left_ff, blk_left_in;
   logic [34:0] raw_left_ff, raw_left_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        adv;
   logic [7:0]  byte_v;
   logic        feed_crc;
   logic        feed_adl;
   logic        crc_rst;
   logic        last_b;
   logic        fend;
   logic        err;
   logic        hdr_need;
   logic [15:0] hdr_n;
   logic        hdr_fin;
   logic [31:0] crc_x;
   logic [15:0] lo_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_START;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= CRC_INIT;
         adl_lo_ff    <= 16'd1;
         adl_hi_ff    <= '0;
         blk_left_ff  <= '0;
         raw_left_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         crc_ff       <= crc_in;
         adl_lo_ff    <= adl_lo_in;
         adl_hi_ff    <= adl_hi_in;
         blk_left_ff  <= blk_left_in;
         raw_left_ff  <= raw_left_in;
      end
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      rsel_ff     <= rsel_in;
      hdr_idx_ff  <= hdr_idx_in;
      hdr_done_ff <= hdr_done_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      rsel_in      = rsel_ff;
      hdr_idx_in   = hdr_idx_ff;
      hdr_done_in  = hdr_done_ff;
      crc_in       = crc_ff;
      adl_lo_in    = adl_lo_ff;
      adl_hi_in    = adl_hi_ff;
      blk_left_in  = blk_left_ff;
      raw_left_in  = raw_left_ff;
      rsp_in       = rsp_ff;

      adv      = cur_valid_ff && (!rsp_valid_ff || rsp_ready);
      crc_x    = ~crc_ff;
      hdr_n    = (raw_left_ff < {19'd0, BLK_SIZE}) ? raw_left_ff[15:0] : BLK_SIZE;
      hdr_fin  = raw_left_ff <= {19'd0, BLK_SIZE};
      hdr_need = (blk_left_ff == 16'd0) && !hdr_done_ff;
      byte_v   = '0;
      feed_crc = 1'b0;
      feed_adl = 1'b0;
      crc_rst  = 1'b0;
      last_b   = 1'b0;
      fend     = 1'b0;
      err      = 1'b0;

      unique case (state_ff)
         BK_START: begin
            case (idx_ff)
               6'd0:  byte_v = 8'h89;
               6'd1:  byte_v = 8'h50;
               6'd2:  byte_v = 8'h4E;
               6'd3:  byte_v = 8'h47;
               6'd4:  byte_v = 8'h0D;
               6'd5:  byte_v = 8'h0A;
               6'd6:  byte_v = 8'h1A;
               6'd7:  byte_v = 8'h0A;
               6'd11: byte_v = 8'h0D;
               6'd12: byte_v = 8'h49;
               6'd13: byte_v = 8'h48;
               6'd14: byte_v = 8'h44;
               6'd15: byte_v = 8'h52;
               6'd18: byte_v = cur_ff.width[15:8];
               6'd19: byte_v = cur_ff.width[7:0];
               6'd22: byte_v = cur_ff.height[15:8];
               6'd23: byte_v = cur_ff.height[7:0];
               6'd24: byte_v = 8'h08;
               6'd25: byte_v = 8'h02;
               6'd29: byte_v = crc_x[31:24];
               6'd30: byte_v = crc_x[23:16];
               6'd31: byte_v = crc_x[15:8];
               6'd32: byte_v = crc_x[7:0];
               6'd33: byte_v = cur_ff.zlen[31:24];
               6'd34: byte_v = cur_ff.zlen[23:16];
               6'd35: byte_v = cur_ff.zlen[15:8];
               6'd36: byte_v = cur_ff.zlen[7:0];
               6'd37: byte_v = 8'h49;
               6'd38: byte_v = 8'h44;
               6'd39: byte_v = 8'h41;
               6'd40: byte_v = 8'h54;
               6'd41: byte_v = 8'h78;
               6'd42: byte_v = 8'h01;
               default: byte_v = 8'h00;
            endcase
            feed_crc = ((idx_ff >= 6'd12) && (idx_ff <= 6'd28)) || (idx_ff >= 6'd37);
            crc_rst  = (idx_ff == 6'd12) || (idx_ff == 6'd37);
            last_b   = (idx_ff == START_LAST);
         end
         BK_RAW: begin
            feed_crc = 1'b1;
            if (hdr_need) begin
               case (hdr_idx_ff)
                  3'd0:    byte_v = {7'd0, hdr_fin};
                  3'd1:    byte_v = hdr_n[7:0];
                  3'd2:    byte_v = hdr_n[15:8];
                  3'd3:    byte_v = ~hdr_n[7:0];
                  default: byte_v = ~hdr_n[15:8];
               endcase
            end else begin
               feed_adl = 1'b1;
               case (rsel_ff)
                  2'd0:    byte_v = 8'h00;
                  2'd1:    byte_v = cur_ff.red;
                  2'd2:    byte_v = cur_ff.green;
                  default: byte_v = cur_ff.blue;
               endcase
               last_b = (rsel_ff == 2'd3) && !cur_ff.last_pix;
            end
         end
         BK_TRAIL: begin
            case (idx_ff)
               6'd0:  byte_v = adl_hi_ff[15:8];
               6'd1:  byte_v = adl_hi_ff[7:0];
               6'd2:  byte_v = adl_lo_ff[15:8];
               6'd3:  byte_v = adl_lo_ff[7:0];
               6'd4:  byte_v = crc_x[31:24];
               6'd5:  byte_v = crc_x[23:16];
               6'd6:  byte_v = crc_x[15:8];
               6'd7:  byte_v = crc_x[7:0];
               6'd12: byte_v = 8'h49;
               6'd13: byte_v = 8'h45;
               6'd14: byte_v = 8'h4E;
               6'd15: byte_v = 8'h44;
               6'd16: byte_v = crc_x[31:24];
               6'd17: byte_v = crc_x[23:16];
               6'd18: byte_v = crc_x[15:8];
               6'd19: byte_v = crc_x[7:0];
               default: byte_v = 8'h00;
            endcase
            feed_crc = (idx_ff <= 6'd3) || ((idx_ff >= 6'd12) && (idx_ff <= 6'd15));
            crc_rst  = (idx_ff == 6'd12);
            last_b   = (idx_ff == TRAIL_LAST);
            fend     = last_b;
         end
         BK_ERR: begin
            err    = 1'b1;
            last_b = 1'b1;
         end
         default: last_b = 1'b1;
      endcase

      lo_new = adler_mod({1'b0, adl_lo_ff} + {9'd0, byte_v});

      if (adv) begin
         rsp_in.out_byte    = byte_v;
         rsp_in.last_of_run = last_b;
         rsp_in.file_end    = fend;
         rsp_in.error       = err;
         rsp_valid_in       = 1'b1;
         if (feed_crc) begin
            crc_in = crc_byte(crc_rst ? CRC_INIT : crc_ff, byte_v);
         end
         if (feed_adl) begin
            adl_lo_in = lo_new;
            adl_hi_in = adler_mod({1'b0, adl_hi_ff} + {1'b0, lo_new});
         end
         unique case (state_ff)
            BK_START: begin
               idx_in = idx_ff + 6'd1;
               if (last_b) begin
                  adl_lo_in   = 16'd1;
                  adl_hi_in   = '0;
                  blk_left_in = '0;
                  raw_left_in = cur_ff.raw_len;
               end
            end
            BK_RAW: begin
               if (hdr_need) begin
                  hdr_idx_in = hdr_idx_ff + 3'd1;
                  if (hdr_idx_ff == 3'd4) begin
                     hdr_idx_in  = '0;
                     hdr_done_in = 1'b1;
                     blk_left_in = hdr_n;
                  end
               end else begin
                  hdr_done_in = 1'b0;
                  rsel_in     = rsel_ff + 2'd1;
                  if (blk_left_ff != 16'd0) begin
                     blk_left_in = blk_left_ff - 16'd1;
                  end
                  if (raw_left_ff != 35'd0) begin
                     raw_left_in = raw_left_ff - 35'd1;
                  end
                  if ((rsel_ff == 2'd3) && cur_ff.last_pix) begin
                     state_in = BK_TRAIL;
                     idx_in   = '0;
                  end
               end
            end
            BK_TRAIL: idx_in = idx_ff + 6'd1;
            BK_ERR:   idx_in = idx_ff;
            default:  idx_in = idx_ff;
         endcase
         if (last_b) begin
            cur_valid_in = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      // The next command is popped when none is held, or in the cycle the current one sends its last byte.
      q_pop = q_valid && (!cur_valid_ff || (adv && last_b));
      if (q_pop) begin
         cur_in       = q_head;
         cur_valid_in = 1'b1;
         idx_in       = '0;
         rsel_in      = q_head.first_col ? 2'd0 : 2'd1;
         hdr_idx_in   = '0;
         hdr_done_in  = 1'b0;
         unique case (q_head.kind)
            CMD_START: state_in = BK_START;
            CMD_PIXEL: state_in = BK_RAW;
            CMD_ERROR: state_in = BK_ERR;
            default:   state_in = BK_ERR;
         endcase
      end

      rsp_valid   = rsp_valid_ff;
      rsp_payload = rsp_ff;
   end

endmodule

/* src/png_stored_stream_encoder.sv */
// PNG stored-stream encoder. A start request (op 0) latches the width and height
// registers (zero reads as one) and produces 43 bytes: signature, IHDR with its
// CRC, the IDAT length and type and the zlib header. Each pixel request (op 1)
// produces its red, green and blue bytes, preceded by a zero filter byte at the
// start of a row and by a 5-byte stored-block header wherever a block of up to
// BLOCK_MAX bytes begins; the last pixel of the image also produces 20 trailer
// bytes (Adler-32, IDAT CRC, IEND) and flags the final one with file_end. A pixel
// with no image open produces a single error byte. Every byte is one response,
// and last_of_run marks the final response of a request. The output side sends
// one byte per cycle while the response side takes them, from the single byte
// sequencer in the back part. Pixel requests are taken one per cycle while the
// four-entry command queue has room. A start request holds the request side
// while the front part multiplies out the raw data length, divides it by the
// block size through a reciprocal multiplication and a short correction loop
// and waits for room in the queue. The configuration port always accepts;
// registers are to be written only while the encoder is idle, a rule on the
// user that the encoder itself leaves unchecked; they take effect at the next
// start.
module png_stored_stream_encoder #(
   parameter int BLOCK_MAX = 65535
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pse_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pse_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);
   import pse_pkg::*;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic        q_full;
   logic        q_push;
   cmd_type     q_wdata;
   logic        q_pop;
   logic        q_valid;
   cmd_type     q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 16'd1;
         height_ff <= 16'd1;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Register writes; nothing else is addressed, so the port never stalls.
   always_comb begin
      csr_ready = 1'b1;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_WIDTH:  width_in  = csr_wdata;
            REG_HEIGHT: height_in = csr_wdata;
            default:    width_in  = width_ff;
         endcase
      end
   end

   // The front part classifies requests and tracks the row and column.
   pse_front #(.BLOCK_MAX(BLOCK_MAX)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .image_width  (width_ff),
      .image_height (height_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_wdata)
   );

   pse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_wdata),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   // The back part produces the byte stream and the running checksums.
   pse_back #(.BLOCK_MAX(BLOCK_MAX)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* src/pse_checker.sv */
// Port-level checks for the PNG stored-stream encoder, bound to its top level.
// Depends on pse_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pse_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pse_pkg::rsp_type rsp_payload
);
   import pse_pkg::*;

   // A response that is not taken stays on the port unchanged.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   // The end of the file is always the final byte of its request.
   `ASSERT_IMPL(a_end_last, clock, reset, rsp_valid && rsp_payload.file_end, rsp_payload.last_of_run)
   // An error is a lone zero byte that never ends a file.
   `ASSERT_IMPL(a_err_form, clock, reset, rsp_valid && rsp_payload.error, rsp_payload.last_of_run && rsp_payload.out_byte == 8'd0 && !rsp_payload.file_end)
   // Reset leaves no response pending.
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind png_stored_stream_encoder pse_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

/* tb/sv/png_stored_stream_encoder_tb.sv */
// Self-checking testbench for png_stored_stream_encoder: directed rows from a stimulus table,
// then random images, all checked byte by byte against a predictor.
// Depends on pse_pkg and the png_stored_stream_encoder RTL.
module png_stored_stream_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pse_pkg::*;

   // Register indexes of the configuration port.
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // Which running checksums a byte feeds.
   localparam int FEED_NONE  = 0;
   localparam int FEED_CRC   = 1;
   localparam int FEED_ADLER = 2;
   localparam int FEED_BOTH  = 3;

   localparam int unsigned STORED_BLOCK = 65535;
   localparam int          DRAIN_CYCLES = 80;

   typedef enum logic [1:0] {
      ROW_REQUEST,
      ROW_SET_WIDTH,
      ROW_SET_HEIGHT
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      request;
      logic [15:0]  value;
      bit           pinned;
      rsp_type      first_byte;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   png_stored_stream_encoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #4ms;
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor: its own copy of the encoder state. Every byte goes through png_byte, which
   // keeps the most recent one back so the last byte of a request can get its flags.
   // ---------------------------------------------------------------------------------------
   logic [31:0]     crc_acc;
   logic [15:0]     adler_a, adler_b;
   logic [15:0]     col_pos, row_pos, block_remaining;
   longint unsigned scan_bytes_left;
   bit              image_active;
   logic [15:0]     width_setting = 16'd1, height_setting = 16'd1;
   logic [31:0]     image_w, image_h;

   rsp_type png_bytes_due[$];
   rsp_type held_byte;
   bit      have_held;
   int      mismatches = 0;
   int      bytes_taken = 0;

   function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
      c = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) c = c[0] ? (32'hEDB88320 ^ (c >> 1)) : (c >> 1);
      return c;
   endfunction

   task automatic png_byte(input logic [7:0] b, input int feed);
      if (feed & FEED_CRC) crc_acc = crc_next(crc_acc, b);
      if (feed & FEED_ADLER) begin
         adler_a = 16'((32'(adler_a) + 32'(b)) % 65521);
         adler_b = 16'((32'(adler_b) + 32'(adler_a)) % 65521);
      end
      if (have_held) png_bytes_due.insert(png_bytes_due.size(), held_byte);
      held_byte = '{out_byte: b, last_of_run: 1'b0, file_end: 1'b0, error: 1'b0};
      have_held = 1'b1;
   endtask

   task automatic png_word(input logic [31:0] w, input int feed);
      png_byte(w[31:24], feed);
      png_byte(w[23:16], feed);
      png_byte(w[15:8], feed);
      png_byte(w[7:0], feed);
   endtask

   // One scanline byte; opens a stored block with its 5-byte header when needed.
   task automatic scan_byte(input logic [7:0] b);
      logic [15:0] len;
      if (block_remaining == 0) begin
         len = (scan_bytes_left < STORED_BLOCK) ? 16'(scan_bytes_left) : 16'(STORED_BLOCK);
         png_byte((scan_bytes_left <= STORED_BLOCK) ? 8'd1 : 8'd0, FEED_CRC);
         png_byte(len[7:0], FEED_CRC);
         png_byte(len[15:8], FEED_CRC);
         png_byte(~len[7:0], FEED_CRC);
         png_byte(~len[15:8], FEED_CRC);
         block_remaining = len;
      end
      png_byte(b, FEED_BOTH);
      if (block_remaining != 0) block_remaining--;
      if (scan_bytes_left != 0) scan_bytes_left--;
   endtask

   task automatic open_image();
      longint unsigned blocks, zlib_len;
      image_w = (width_setting == 0) ? 32'd1 : 32'(width_setting);
      image_h = (height_setting == 0) ? 32'd1 : 32'(height_setting);
      scan_bytes_left = longint'(image_h) * (longint'(image_w) * 3 + 1);
      blocks = (scan_bytes_left + STORED_BLOCK - 1) / STORED_BLOCK;
      zlib_len = 2 + scan_bytes_left + 5 * blocks + 4;
      png_word(32'h89504E47, FEED_NONE);
      png_word(32'h0D0A1A0A, FEED_NONE);
      png_word(32'd13, FEED_NONE);
      crc_acc = 32'hFFFFFFFF;
      png_word(32'h49484452, FEED_CRC);             // IHDR
      png_word(image_w, FEED_CRC);
      png_word(image_h, FEED_CRC);
      png_byte(8'd8, FEED_CRC);                     // bit depth
      png_byte(8'd2, FEED_CRC);                     // truecolour
      png_byte(8'd0, FEED_CRC);
      png_byte(8'd0, FEED_CRC);
      png_byte(8'd0, FEED_CRC);
      png_word(~crc_acc, FEED_NONE);
      png_word(zlib_len[31:0], FEED_NONE);
      crc_acc = 32'hFFFFFFFF;
      png_word(32'h49444154, FEED_CRC);             // IDAT
      png_byte(8'h78, FEED_CRC);
      png_byte(8'h01, FEED_CRC);
      adler_a = 16'd1;
      adler_b = 16'd0;
      col_pos = 0;
      row_pos = 0;
      block_remaining = 0;
      image_active = 1'b1;
   endtask

   task automatic close_image();
      png_word({adler_b, adler_a}, FEED_CRC);
      png_word(~crc_acc, FEED_NONE);
      png_word(32'd0, FEED_NONE);
      crc_acc = 32'hFFFFFFFF;
      png_word(32'h49454E44, FEED_CRC);             // IEND
      png_word(~crc_acc, FEED_NONE);
      held_byte.file_end = 1'b1;
      image_active = 1'b0;
   endtask

   task automatic predict_request(input req_type r);
      have_held = 1'b0;
      if (r.op == OP_START) begin
         open_image();
      end else if (!image_active) begin
         held_byte = '{out_byte: 8'd0, last_of_run: 1'b0, file_end: 1'b0, error: 1'b1};
         have_held = 1'b1;
      end else begin
         if (col_pos == 0) scan_byte(8'd0);         // filter byte of the row
         scan_byte(r.red);
         scan_byte(r.green);
         scan_byte(r.blue);
         col_pos++;
         if (32'(col_pos) >= image_w) begin
            col_pos = 0;
            row_pos++;
            if (32'(row_pos) >= image_h) close_image();
         end
      end
      held_byte.last_of_run = 1'b1;
      png_bytes_due.insert(png_bytes_due.size(), held_byte);
   endtask

   initial begin
      crc_acc = 32'hFFFFFFFF;
      adler_a = 16'd1;
      adler_b = 16'd0;
      col_pos = 0;
      row_pos = 0;
      block_remaining = 0;
      scan_bytes_left = 0;
      image_active = 1'b0;
      image_w = 1;
      image_h = 1;
   end

   // ---------------------------------------------------------------------------------------
   // Response side: random back-pressure, plus a long hold-off when the stimulus asks for it.
   // ---------------------------------------------------------------------------------------
   int rx_idle_pct = 0, tx_idle_pct = 0;
   int holds_asked = 0, holds_served = 0, hold_left = 0;

   always @(posedge clock) begin
      if (holds_asked != holds_served) begin
         holds_served <= holds_asked;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Each delivered byte is compared with the oldest one still due.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (png_bytes_due.size() == 0) begin
            $display("%t: unexpected byte, expected none, actual %p", $realtime, rsp_payload);
            mismatches++;
         end else begin
            want = png_bytes_due.pop_front();
            bytes_taken++;
            if (rsp_payload.out_byte !== want.out_byte ||
                rsp_payload.last_of_run !== want.last_of_run ||
                rsp_payload.file_end !== want.file_end ||
                rsp_payload.error !== want.error) begin
               $display("%t: byte mismatch, expected %p, actual %p",
                        $realtime, want, rsp_payload);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Request side.
   // ---------------------------------------------------------------------------------------
   task automatic send_request(input req_type r);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      predict_request(r);
   endtask

   // Stop sending and let every due byte arrive, then give the encoder time to settle so a
   // register write cannot land while it is still busy.
   task automatic drain();
      req_valid <= 1'b0;
      while (png_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_WIDTH) width_setting = value;
      else height_setting = value;
      @(posedge clock);
   endtask

   function automatic req_type pixel(input logic [7:0] r, g, b);
      return '{op: OP_PIXEL, red: r, green: g, blue: b};
   endfunction

   function automatic req_type random_pixel();
      return pixel(8'($urandom), 8'($urandom), 8'($urandom));
   endfunction

   function automatic req_type start_request(input logic [7:0] junk);
      return '{op: OP_START, red: junk, green: ~junk, blue: junk};
   endfunction

   localparam rsp_type ERROR_BYTE = '{out_byte: 8'h00, last_of_run: 1'b1, file_end: 1'b0,
                                      error: 1'b1};
   localparam rsp_type SIGNATURE_BYTE = '{out_byte: 8'h89, last_of_run: 1'b0, file_end: 1'b0,
                                          error: 1'b0};

   stim_row_type directed[$];

   task automatic add_request(input req_type r, input bit pin = 0, input rsp_type first = '0);
      directed.insert(directed.size(), '{kind: ROW_REQUEST, request: r, value: '0,
                                         pinned: pin, first_byte: first});
   endtask

   task automatic add_register(input row_kind_type k, input logic [15:0] v);
      directed.insert(directed.size(), '{kind: k, request: '0, value: v, pinned: 0,
                                         first_byte: '0});
   endtask

   // One random image: start, then mostly the full pixel count; sometimes it is cut short by
   // a new start, and sometimes a stray pixel follows it.
   task automatic random_image(inout int sent);
      int pixels, stop_at;
      drain();
      if ($urandom_range(9) == 0) begin
         write_register(REG_WIDTH, 16'($urandom_range(40, 1)));
         write_register(REG_HEIGHT, 16'($urandom_range(3, 1)));
      end else begin
         write_register(REG_WIDTH, 16'($urandom_range(6, 1)));
         write_register(REG_HEIGHT, 16'($urandom_range(6, 1)));
      end
      pixels = int'(width_setting) * int'(height_setting);
      stop_at = ($urandom_range(7) == 0) ? $urandom_range(pixels - 1, 0) : pixels;
      send_request(start_request(8'($urandom)));
      sent++;
      for (int p = 0; p < stop_at; p++) begin
         send_request(random_pixel());
         sent++;
      end
      // A start in the middle of an image abandons it; the next start opens a fresh one.
      if (stop_at < pixels) begin
         send_request(start_request(8'($urandom)));
         sent++;
         for (int p = 0; p < pixels; p++) begin
            send_request(random_pixel());
            sent++;
         end
      end
      if ($urandom_range(5) == 0) begin
         send_request(random_pixel());
         sent++;
      end
   endtask

   initial begin
      int sent;
      int mark;

      // Directed rows. An error byte and the first signature byte are known at a glance;
      // everything else is left to the predictor.
      add_request(pixel(8'hFF, 8'hFF, 8'hFF), 1, ERROR_BYTE);          // no image open
      add_request(start_request(8'h00), 1, SIGNATURE_BYTE);            // 1x1 after reset
      add_request(pixel(8'hFF, 8'h00, 8'hFF));                         // completes the image
      add_request(pixel(8'h00, 8'hFF, 8'h00), 1, ERROR_BYTE);          // after file end
      add_register(ROW_SET_WIDTH, 16'd0);                              // zero reads as one
      add_register(ROW_SET_HEIGHT, 16'd0);
      add_request(start_request(8'hA5), 1, SIGNATURE_BYTE);
      add_request(pixel(8'h00, 8'h00, 8'h00));
      add_register(ROW_SET_WIDTH, 16'hFFFF);                           // largest image:
      add_register(ROW_SET_HEIGHT, 16'hFFFF);                          // length truncated,
      add_request(start_request(8'hFF), 1, SIGNATURE_BYTE);            // first block not final
      add_request(pixel(8'hFF, 8'hFF, 8'hFF));
      add_request(pixel(8'h00, 8'h00, 8'h00));
      add_request(start_request(8'h5A), 1, SIGNATURE_BYTE);            // abandons it
      add_request(pixel(8'h12, 8'h34, 8'h56));
      add_register(ROW_SET_WIDTH, 16'd2);
      add_register(ROW_SET_HEIGHT, 16'd2);
      add_request(start_request(8'h00), 1, SIGNATURE_BYTE);
      add_request(pixel(8'h80, 8'h01, 8'h7F));
      add_request(pixel(8'h01, 8'h80, 8'hFE));
      add_request(pixel(8'hAA, 8'h55, 8'hAA));
      add_request(pixel(8'h55, 8'hAA, 8'h55));
      add_request(pixel(8'h00, 8'h00, 8'h00), 1, ERROR_BYTE);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Sender idles rarely and receiver often during the directed rows.
      tx_idle_pct = 24;
      rx_idle_pct = 71;
      foreach (directed[i]) begin
         case (directed[i].kind)
            ROW_SET_WIDTH: begin
               drain();
               write_register(REG_WIDTH, directed[i].value);
            end
            ROW_SET_HEIGHT: begin
               drain();
               write_register(REG_HEIGHT, directed[i].value);
            end
            default: begin
               // Count from the start of the stream so bytes taken meanwhile do not shift it.
               mark = png_bytes_due.size() + bytes_taken;
               send_request(directed[i].request);
               mark = mark - bytes_taken;
               if (directed[i].pinned && png_bytes_due[mark] !== directed[i].first_byte) begin
                  $display("%t: row %0d first byte, expected %p, predicted %p", $realtime, i,
                           directed[i].first_byte, png_bytes_due[mark]);
                  mismatches++;
               end
            end
         endcase
      end

      // Random images in three idling phases.
      sent = 0;
      while (sent < 110) random_image(sent);

      // Hold the receiver off for a long stretch while requests keep coming in, so the
      // command queue fills and the request side stalls.
      drain();
      write_register(REG_WIDTH, 16'd8);
      write_register(REG_HEIGHT, 16'd3);
      holds_asked++;
      send_request(start_request(8'h3C));
      for (int p = 0; p < 24; p++) send_request(random_pixel());
      sent += 25;

      tx_idle_pct = 71;
      rx_idle_pct = 24;
      while (sent < 220) random_image(sent);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      while (sent < 320) random_image(sent);

      drain();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
